[hw/rtl/hlwbd_pkg.sv]
// ----------------------------------------------------------------------------
// Heartbeat LED wave and buzzer driver package
// Shared payload types, widths, register indexes and beep phase codes.
// ----------------------------------------------------------------------------
package hlwbd_pkg;

    localparam int TIME_W       = 32;
    localparam int BPM_W        = 12;
    localparam int LED_FIELD_W  = 5;
    localparam int LED_IDX_W    = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int DIVIDEND_W   = 20;
    localparam int DIVISOR_W    = 12;
    localparam int DIV_CNT_W    = 5;
    localparam int INTERVAL_W   = 20;
    localparam int SPACING_W    = 18;
    localparam int LO_W         = 20;

    // The LED spacing is one fifth of the beat interval, which equals the
    // quotient of this dividend by the rate.
    localparam logic [DIVIDEND_W-1:0] BEAT_DIVIDEND    = 20'd960000;
    localparam logic [DIVIDEND_W-1:0] SPACING_DIVIDEND = 20'd192000;

    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_ON_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX    = 3'd5;

    localparam logic [1:0] PH_FIRST_ON  = 2'd0;
    localparam logic [1:0] PH_GAP       = 2'd1;
    localparam logic [1:0] PH_SECOND_ON = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [BPM_W-1:0]  bpm_q;
        logic              finger_on;
        logic              pulse_request;
    } in_item_t;

    typedef struct packed {
        logic [LED_FIELD_W-1:0] leds;
        logic                   buzzer;
    } out_item_t;

endpackage

[hw/rtl/hlwbd_divider.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring radix-2 divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hlwbd_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [hlwbd_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [hlwbd_pkg::DIVISOR_W-1:0]  divisor,
    output logic                             busy,
    output logic [hlwbd_pkg::DIVIDEND_W-1:0] quotient
);
    import hlwbd_pkg::*;

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end else if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/heartbeat_led_wave_buzzer_driver_top.sv]
// ----------------------------------------------------------------------------
// Heartbeat LED wave and buzzer driver, top level
// Turns each timed heart-rate update into LED wave levels and a buzzer level.
// ----------------------------------------------------------------------------
// An update is taken when the block is idle and produces exactly one result.
// Alarm, no-finger and out-of-range updates go from evaluation straight to
// output. For a valid rate, the beat interval and the LED spacing are each
// computed by twenty steps of one shared serial divider, and the LED windows
// are then checked one LED per cycle. The next update is accepted while an
// earlier result still waits to be transferred.
module heartbeat_led_wave_buzzer_driver_top #(
    parameter int LED_COUNT = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hlwbd_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hlwbd_pkg::out_item_t             m_data,
    input  logic                             cfg_we,
    input  logic [hlwbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlwbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hlwbd_pkg::*;

    localparam int NUM_LEDS = (LED_COUNT < LED_FIELD_W) ? LED_COUNT : LED_FIELD_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_DIV1 = 8'b0000_0100,
        S_BEAT = 8'b0000_1000,
        S_BEEP = 8'b0001_0000,
        S_DIV2 = 8'b0010_0000,
        S_LED  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [15:0] alarm_ms_reg;
    logic [11:0] led_on_ms_reg;
    logic [9:0]  beep_on_ms_reg;
    logic [9:0]  beep_gap_ms_reg;
    logic [7:0]  rate_min_reg;
    logic [7:0]  rate_max_reg;

    in_item_t    item_reg;
    logic        finger_before_reg;
    logic        alarm_on_reg;
    logic [TIME_W-1:0] alarm_start_reg;
    logic [TIME_W-1:0] beat_time_reg;
    logic        beep_active_reg;
    logic [1:0]  beep_phase_reg;
    logic [TIME_W-1:0] beep_mark_reg;
    logic        pulse_pending_reg;
    logic        buzzer_reg;

    logic [INTERVAL_W-1:0]  interval_reg;
    logic [SPACING_W-1:0]   spacing_reg;
    logic [LO_W-1:0]        lo_reg;
    logic [LED_IDX_W-1:0]   led_idx_reg;
    logic [LED_FIELD_W-1:0] leds_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic [DIVIDEND_W-1:0] div_quotient;

    logic              finger_fell;
    logic              pulse_now;
    logic [TIME_W-1:0] alarm_elapsed;
    logic              rate_ok;
    logic [TIME_W-1:0] since_beat;
    logic [TIME_W-1:0] beep_elapsed;
    logic [LO_W:0]     hi_sum;
    logic              led_hit;
    logic              out_free;

    hlwbd_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign finger_fell   = finger_before_reg && !item_reg.finger_on;
    assign pulse_now     = pulse_pending_reg || item_reg.pulse_request;
    assign alarm_elapsed = finger_fell ? '0 : item_reg.now_ms - alarm_start_reg;
    assign rate_ok       = (item_reg.bpm_q != '0)
                        && (item_reg.bpm_q >= {rate_min_reg, 4'b0000})
                        && (item_reg.bpm_q <= {rate_max_reg, 4'b0000});
    assign since_beat    = item_reg.now_ms - beat_time_reg;
    assign beep_elapsed  = item_reg.now_ms - beep_mark_reg;
    assign hi_sum        = {1'b0, lo_reg} + (LO_W + 1)'(led_on_ms_reg);
    assign led_hit       = (since_beat >= TIME_W'(lo_reg)) && (since_beat < TIME_W'(hi_sum));
    assign out_free      = !m_valid_reg || m_ready;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = BEAT_DIVIDEND;
        div_divisor  = item_reg.bpm_q;
        if (state_reg == S_EVAL) begin
            div_start = !alarm_on_reg && !finger_fell && item_reg.finger_on && rate_ok;
        end else if (state_reg == S_DIV1 && !div_busy) begin
            div_start    = 1'b1;
            div_dividend = SPACING_DIVIDEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_ms_reg    <= 16'd7000;
            led_on_ms_reg   <= 12'd120;
            beep_on_ms_reg  <= 10'd100;
            beep_gap_ms_reg <= 10'd50;
            rate_min_reg    <= 8'd20;
            rate_max_reg    <= 8'd200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ALARM_MS:    alarm_ms_reg    <= cfg_wdata;
                REG_LED_ON_MS:   led_on_ms_reg   <= cfg_wdata[11:0];
                REG_BEEP_ON_MS:  beep_on_ms_reg  <= cfg_wdata[9:0];
                REG_BEEP_GAP_MS: beep_gap_ms_reg <= cfg_wdata[9:0];
                REG_RATE_MIN:    rate_min_reg    <= cfg_wdata[7:0];
                REG_RATE_MAX:    rate_max_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            finger_before_reg <= 1'b0;
            alarm_on_reg      <= 1'b0;
            alarm_start_reg   <= '0;
            beat_time_reg     <= '0;
            beep_active_reg   <= 1'b0;
            beep_phase_reg    <= PH_FIRST_ON;
            beep_mark_reg     <= '0;
            pulse_pending_reg <= 1'b0;
            buzzer_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    pulse_pending_reg <= pulse_now;
                    finger_before_reg <= item_reg.finger_on;
                    if (finger_fell) begin
                        alarm_start_reg <= item_reg.now_ms;
                    end
                    if (alarm_on_reg || finger_fell) begin
                        alarm_on_reg    <= alarm_elapsed < TIME_W'(alarm_ms_reg);
                        buzzer_reg      <= alarm_elapsed < TIME_W'(alarm_ms_reg);
                        beep_active_reg <= 1'b0;
                        leds_reg        <= '0;
                        state_reg       <= S_OUT;
                    end else if (!item_reg.finger_on) begin
                        buzzer_reg      <= 1'b0;
                        beep_active_reg <= 1'b0;
                        leds_reg        <= '0;
                        state_reg       <= S_OUT;
                    end else if (!rate_ok) begin
                        buzzer_reg      <= 1'b0;
                        beep_active_reg <= 1'b0;
                        leds_reg        <= LED_FIELD_W'(1);
                        state_reg       <= S_OUT;
                    end else begin
                        leds_reg  <= '0;
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (!div_busy) begin
                        interval_reg <= div_quotient;
                        state_reg    <= S_BEAT;
                    end
                end
                S_BEAT: begin
                    if (pulse_pending_reg || since_beat >= TIME_W'(interval_reg)) begin
                        pulse_pending_reg <= 1'b0;
                        beat_time_reg     <= item_reg.now_ms;
                        beep_active_reg   <= 1'b1;
                        beep_mark_reg     <= item_reg.now_ms;
                        beep_phase_reg    <= PH_FIRST_ON;
                        buzzer_reg        <= 1'b1;
                    end
                    state_reg <= S_BEEP;
                end
                S_BEEP: begin
                    if (beep_active_reg) begin
                        case (beep_phase_reg)
                            PH_FIRST_ON: begin
                                if (beep_elapsed >= TIME_W'(beep_on_ms_reg)) begin
                                    buzzer_reg     <= 1'b0;
                                    beep_phase_reg <= PH_GAP;
                                    beep_mark_reg  <= item_reg.now_ms;
                                end
                            end
                            PH_GAP: begin
                                if (beep_elapsed >= TIME_W'(beep_gap_ms_reg)) begin
                                    buzzer_reg     <= 1'b1;
                                    beep_phase_reg <= PH_SECOND_ON;
                                    beep_mark_reg  <= item_reg.now_ms;
                                end
                            end
                            PH_SECOND_ON: begin
                                if (beep_elapsed >= TIME_W'(beep_on_ms_reg)) begin
                                    buzzer_reg      <= 1'b0;
                                    beep_active_reg <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    state_reg <= S_DIV2;
                end
                S_DIV2: begin
                    if (!div_busy) begin
                        spacing_reg <= div_quotient[SPACING_W-1:0];
                        lo_reg      <= '0;
                        led_idx_reg <= '0;
                        state_reg   <= S_LED;
                    end
                end
                S_LED: begin
                    leds_reg[led_idx_reg] <= led_hit;
                    lo_reg      <= lo_reg + LO_W'(spacing_reg);
                    led_idx_reg <= led_idx_reg + 1'b1;
                    if (led_idx_reg == LED_IDX_W'(NUM_LEDS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {leds_reg, buzzer_reg};
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
